FILE: hw/rtl/tea_pkg.sv
// Shared types, constants and the round mixing function for the TEA pipeline.
package tea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;
  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] KEY_WORD0_IDX = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD1_IDX = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD2_IDX = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD3_IDX = 8'd3;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] left_word;
    logic [31:0] right_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] left_result;
    logic [31:0] right_result;
  } out_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] left;
    logic [31:0] right;
  } stage_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } key_t;

  function automatic logic [31:0] mix_half(input logic [31:0] v, input logic [31:0] sum,
                                           input logic [31:0] ka, input logic [31:0] kb);
    mix_half = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

FILE: hw/rtl/tea_cell.sv
// One half round of TEA: updates one half of the block and hands it on.
module tea_cell #(
  parameter logic [31:0] ENC_SUM = 32'h0,
  parameter logic [31:0] DEC_SUM = 32'h0,
  parameter bit          SECOND  = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tea_pkg::key_t   key,
  input  logic            up_valid,
  output logic            up_ready,
  input  tea_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output tea_pkg::stage_t dn_data
);
  import tea_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;
  logic [31:0] sum;
  logic [31:0] src;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] mix;
  logic        use_left;   // mix the left half into the right half

  // Encrypt: first half updates left from right, second updates right.
  // Decrypt runs the two halves in the opposite order and subtracts.
  always_comb begin
    use_left = (up_data.kind == KIND_DECRYPT) ? !SECOND : SECOND;
    sum      = (up_data.kind == KIND_DECRYPT) ? DEC_SUM : ENC_SUM;
    src      = use_left ? up_data.left : up_data.right;
    ka       = use_left ? key.w2 : key.w0;
    kb       = use_left ? key.w3 : key.w1;
    mix      = mix_half(src, sum, ka, kb);
    data_nxt = up_data;
    if (up_data.kind == KIND_DECRYPT) begin
      if (use_left) data_nxt.right = up_data.right - mix;
      else          data_nxt.left  = up_data.left - mix;
    end else begin
      if (use_left) data_nxt.right = up_data.right + mix;
      else          data_nxt.left  = up_data.left + mix;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: hw/rtl/tea_block_cipher.sv
// Top level: key registers and a chain of half-round cells running TEA.
// Throughput: one item per cycle while out_ready is held high; each round is split over two half-round cells.
// Each cell holds its item until the next one frees, so a stalled result backs up the chain.
// Reset (synchronous, rst_n low) clears all key words to zero and empties the chain.
module tea_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tea_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tea_pkg::out_item_t                  out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tea_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data
);
  import tea_pkg::*;

  localparam int unsigned STAGES = 2 * ROUNDS;

  key_t   key_r;
  stage_t stg [STAGES+1];
  logic [STAGES:0] vld;
  logic [STAGES:0] rdy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        KEY_WORD0_IDX: key_r.w0 <= cfg_data;
        KEY_WORD1_IDX: key_r.w1 <= cfg_data;
        KEY_WORD2_IDX: key_r.w2 <= cfg_data;
        KEY_WORD3_IDX: key_r.w3 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign stg[0].kind  = in_item.kind;
  assign stg[0].left  = in_item.left_word;
  assign stg[0].right = in_item.right_word;
  assign vld[0]       = in_valid;
  assign in_ready     = rdy[0];
  assign rdy[STAGES]  = out_ready;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    localparam int unsigned RND = i / 2;
    localparam logic [63:0] ENC_PROD = 64'(RND + 1) * 64'(TEA_DELTA);
    localparam logic [63:0] DEC_PROD = 64'(ROUNDS - RND) * 64'(TEA_DELTA);
    tea_cell #(
      .ENC_SUM (ENC_PROD[31:0]),
      .DEC_SUM (DEC_PROD[31:0]),
      .SECOND  ((i % 2) == 1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key_r),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_data  (stg[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_data  (stg[i+1])
    );
  end

  assign out_valid             = vld[STAGES];
  assign out_item.left_result  = stg[STAGES].left;
  assign out_item.right_result = stg[STAGES].right;

  a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld[1])
    else $error("accepted item did not enter first cell");

  a_first_cell_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld[1] && !rdy[1] |=> vld[1] && $stable(stg[1]))
    else $error("stalled cell lost or changed its item");

  a_key0_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == KEY_WORD0_IDX |=> key_r.w0 == $past(cfg_data))
    else $error("key word 0 write not applied");

endmodule

FILE: test/tb_top.sv
// Testbench for the TEA block cipher pipeline: scoreboard class, channel drivers and phased run.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tea_pkg::*;

  localparam int unsigned NUM_ROUNDS   = 32;
  localparam int unsigned PIPE_LATENCY = 2 * NUM_ROUNDS;
  localparam int unsigned PHASE_BLOCKS = 160;

  typedef enum int {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

  class cipher_scoreboard;
    logic [31:0] key_w [4];
    out_item_t   expected_blocks [$];
    int          errors;
    int          matched;
    int          encrypts;
    int          decrypts;

    function new();
      foreach (key_w[i]) key_w[i] = '0;
      errors   = 0;
      matched  = 0;
      encrypts = 0;
      decrypts = 0;
    endfunction

    function void set_key(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
      case (idx)
        KEY_WORD0_IDX: key_w[0] = data;
        KEY_WORD1_IDX: key_w[1] = data;
        KEY_WORD2_IDX: key_w[2] = data;
        KEY_WORD3_IDX: key_w[3] = data;
        default: ;
      endcase
    endfunction

    function logic [31:0] round_mix(logic [31:0] v, logic [31:0] s,
                                    logic [31:0] ka, logic [31:0] kb);
      logic [31:0] shl_term;
      logic [31:0] sum_term;
      logic [31:0] shr_term;
      shl_term = (v << 4) + ka;
      sum_term = v + s;
      shr_term = (v >> 5) + kb;
      return shl_term ^ sum_term ^ shr_term;
    endfunction

    function out_item_t tea_transform(in_item_t blk);
      logic [31:0] v0;
      logic [31:0] v1;
      logic [31:0] s;
      out_item_t   res;
      v0 = blk.left_word;
      v1 = blk.right_word;
      if (blk.kind == KIND_ENCRYPT) begin
        s = '0;
        for (int r = 0; r < NUM_ROUNDS; r++) begin
          s  = s + TEA_DELTA;
          v0 = v0 + round_mix(v1, s, key_w[0], key_w[1]);
          v1 = v1 + round_mix(v0, s, key_w[2], key_w[3]);
        end
      end else begin
        // start from the sum the encrypt pass ends with, wrapped to 32 bits
        s = TEA_DELTA * NUM_ROUNDS;
        for (int r = 0; r < NUM_ROUNDS; r++) begin
          v1 = v1 - round_mix(v0, s, key_w[2], key_w[3]);
          v0 = v0 - round_mix(v1, s, key_w[0], key_w[1]);
          s  = s - TEA_DELTA;
        end
      end
      res.left_result  = v0;
      res.right_result = v1;
      return res;
    endfunction

    function void note_block(in_item_t blk);
      expected_blocks.push_back(tea_transform(blk));
      if (blk.kind == KIND_ENCRYPT) encrypts++;
      else decrypts++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_blocks.size() == 0) begin
        $error("result with no block outstanding: left %h right %h",
               got.left_result, got.right_result);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      if (got.left_result !== want.left_result) begin
        $error("left_result: expected %h, got %h", want.left_result, got.left_result);
        errors++;
      end
      if (got.right_result !== want.right_result) begin
        $error("right_result: expected %h, got %h", want.right_result, got.right_result);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int key_loads      = 1;

  cipher_scoreboard sb = new();

  tea_block_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check on handshake, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function void set_pace(pace_t p);
    case (p)
      PACE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PACE_SEND: begin
        send_idle_pct  = 72;
        recv_stall_pct = 0;
      end
      PACE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 72;
      end
      default: begin
        send_idle_pct  = 31;
        recv_stall_pct = 31;
      end
    endcase
  endfunction

  function in_item_t corner_block(logic kind, int n);
    in_item_t blk;
    blk.kind = kind;
    case (n)
      0:       begin blk.left_word = 32'h0000_0000; blk.right_word = 32'h0000_0000; end
      1:       begin blk.left_word = 32'hffff_ffff; blk.right_word = 32'hffff_ffff; end
      2:       begin blk.left_word = 32'h0000_0000; blk.right_word = 32'hffff_ffff; end
      3:       begin blk.left_word = 32'hffff_ffff; blk.right_word = 32'h0000_0000; end
      4:       begin blk.left_word = 32'haaaa_aaaa; blk.right_word = 32'h5555_5555; end
      default: begin blk.left_word = 32'h8000_0000; blk.right_word = 32'h0000_0001; end
    endcase
    return blk;
  endfunction

  function in_item_t random_block();
    in_item_t blk;
    blk.kind       = 1'($urandom_range(1));
    blk.left_word  = $urandom;
    blk.right_word = $urandom;
    return blk;
  endfunction

  // Leaves in_valid high after the accept; the next call or drain decides.
  task automatic send_block(input in_item_t blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= blk;
    do @(posedge clk); while (!in_ready);
    sb.note_block(blk);
  endtask

  // Drop valid and hold until every outstanding block has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_blocks.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_key(idx, data);
  endtask

  task automatic load_key(input key_t k, input logic [CFG_INDEX_W-1:0] junk_idx);
    write_reg(KEY_WORD0_IDX, k.w0);
    write_reg(KEY_WORD1_IDX, k.w1);
    write_reg(KEY_WORD2_IDX, k.w2);
    write_reg(KEY_WORD3_IDX, k.w3);
    // an index past the key words must leave the key untouched
    write_reg(junk_idx, $urandom);
    cfg_valid <= 1'b0;
    key_loads++;
  endtask

  initial begin
    key_t  k;
    pace_t pace;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero key straight out of reset
    for (int kd = 0; kd < 2; kd++) begin
      for (int c = 0; c < 6; c++) send_block(corner_block(kd[0], c));
    end
    drain();

    k = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    load_key(k, 8'd255);
    for (int kd = 0; kd < 2; kd++) begin
      send_block(corner_block(kd[0], 0));
      send_block(corner_block(kd[0], 1));
      send_block(corner_block(kd[0], 4));
    end

    for (int p = 0; p < 5; p++) begin
      drain();
      if (p == 3) k = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000};
      else k = '{$urandom, $urandom, $urandom, $urandom};
      load_key(k, (p == 0) ? 8'd4 : 8'($urandom_range(255, 4)));
      case (p)
        0:       pace = PACE_NONE;
        1:       pace = PACE_SEND;
        2:       pace = PACE_RECV;
        default: pace = PACE_BOTH;
      endcase
      set_pace(pace);
      for (int i = 0; i < PHASE_BLOCKS; i++) begin
        if (i == 60) set_pace(PACE_NONE);
        if (i == 90) set_pace(pace);
        if (i == 120) drain();
        send_block(random_block());
      end
    end

    drain();
    repeat (PIPE_LATENCY + 16) @(posedge clk);

    $display("Checked %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings,",
             sb.matched, sb.encrypts, sb.decrypts, key_loads);
    $display("with free-running, sender-idle, receiver-stall and mixed pacing.");
    if (sb.errors == 0 && sb.expected_blocks.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("Regression FAIL");
    $finish;
  end

endmodule
